### design/linear_probe_hash_table_core_macros.svh
// Assertion macros shared by the checker.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LPHT_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("check failed");
// Implication checked in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("check failed");
`endif

### design/lpht_pkg.sv
package lpht_pkg;
	localparam int unsigned TableDepth = 1024;
	localparam int unsigned SlotW = 10;
	localparam int unsigned SizeW = 11;
	localparam logic [30:0] HashPrime = 31'h7fffffff;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic [1:0] REG_MULT = 2'd0;
	localparam logic [1:0] REG_OFFSET = 2'd1;
	localparam logic [1:0] REG_SIZE = 2'd2;

	// Request from the sequencer to the hash unit.
	typedef struct packed {
		logic start;
		logic [31:0] key;
		logic [30:0] mult;
		logic [30:0] offset;
		logic [SizeW-1:0] size;
	} hash_req_t;

	// Answer from the hash unit.
	typedef struct packed {
		logic done;
		logic [SlotW-1:0] home;
	} hash_rsp_t;
endpackage

### design/linear_probe_hash_table_core.sv
// Open-addressing key/value table with linear probing.
// Requests enter on start while busy is low: action, lookup_key, new_value.
// One result appears with done high for exactly one cycle; the receiver
// cannot stall, so the result is simply presented and dropped afterwards.
// Insert and search first find the home slot: two multiply slices, a fold,
// 31 remainder steps in the shared hash unit and a hand-over. Each probed
// slot then passes through the read, wait and check states, since each probe
// reads the slot memories through a registered port, and the result is
// presented through the done state.
// A clear walks every slot before its result; an unused action or a
// zero table size goes straight to the done state.
// busy is high from acceptance until the result cycle, so the next request
// may be taken at the edge that ends the result cycle.
// At reset the used flags are cleared by a pass over all 1024 slots, during
// which busy is high; configuration writes are taken throughout.
// Registers: multiplier at 0x0, offset at 0x4, size at 0x8.
// Reset values are 1, 0 and 1024.
module linear_probe_hash_table_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] action,
	input  logic signed [31:0] lookup_key,
	input  logic signed [31:0] new_value,
	output logic done,
	output logic [2:0] status,
	output logic signed [31:0] found_value,
	output logic [10:0] probe_count,
	output logic [31:0] collision_total,
	output logic [10:0] occupied_total,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [3:0] S_INIT = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_READ = 4'd3;
	localparam logic [3:0] S_WAIT = 4'd4;
	localparam logic [3:0] S_CHECK = 4'd5;
	localparam logic [3:0] S_CLEAR = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;
	localparam int unsigned SW = lpht_pkg::SlotW;
	localparam int unsigned MW = lpht_pkg::SizeW;

	logic [3:0] state_q;
	logic [30:0] mult_q;
	logic [30:0] offset_q;
	logic [MW-1:0] size_q;
	logic [1:0] act_q;
	logic [31:0] key_q;
	logic [31:0] val_q;
	logic [SW-1:0] slot_q;
	logic [MW-1:0] att_q;
	logic [MW-1:0] m_q;
	logic [31:0] coll_q;
	logic [MW-1:0] occ_q;
	logic [2:0] status_q;
	logic [31:0] found_q;
	logic [MW-1:0] probes_q;
	logic done_q;
	logic [SW:0] sweep_q;

	logic used_mem [lpht_pkg::TableDepth];
	logic [31:0] key_mem [lpht_pkg::TableDepth];
	logic [31:0] val_mem [lpht_pkg::TableDepth];
	logic used_rd_q;
	logic [31:0] key_rd_q;
	logic [31:0] val_rd_q;

	lpht_pkg::hash_req_t hreq;
	lpht_pkg::hash_rsp_t hrsp;
	logic [MW-1:0] m_eff;
	logic [MW-1:0] slot_next;
	logic cfg_wr;
	logic used_we;
	logic used_wd;
	logic kv_we;
	logic [SW-1:0] wr_addr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign m_eff = (size_q > MW'(lpht_pkg::TableDepth)) ? MW'(lpht_pkg::TableDepth) : size_q;
	assign slot_next = ({1'b0, slot_q} + 11'd1 >= m_q) ? '0 : {1'b0, slot_q} + 11'd1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= 31'd1;
			offset_q <= '0;
			size_q <= MW'(lpht_pkg::TableDepth);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lpht_pkg::REG_MULT: mult_q <= pwdata[30:0];
				lpht_pkg::REG_OFFSET: offset_q <= pwdata[30:0];
				lpht_pkg::REG_SIZE: size_q <= pwdata[MW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lpht_pkg::REG_MULT: prdata = {1'b0, mult_q};
			lpht_pkg::REG_OFFSET: prdata = {1'b0, offset_q};
			lpht_pkg::REG_SIZE: prdata = {21'b0, size_q};
			default: prdata = '0;
		endcase
	end

	assign hreq.start = (state_q == S_IDLE) && start && (action == lpht_pkg::ACT_INSERT ||
		action == lpht_pkg::ACT_SEARCH) && (m_eff != '0);
	assign hreq.key = lookup_key;
	assign hreq.mult = mult_q;
	assign hreq.offset = offset_q;
	assign hreq.size = m_eff;

	lpht_hash u_hash (
		.clk(clk),
		.arst_n(arst_n),
		.req(hreq),
		.rsp(hrsp)
	);

	// Memory write controls.
	always_comb begin
		used_we = 1'b0;
		used_wd = 1'b0;
		kv_we = 1'b0;
		wr_addr = slot_q;
		if (state_q == S_INIT || state_q == S_CLEAR) begin
			used_we = 1'b1;
			wr_addr = sweep_q[SW-1:0];
		end else if (state_q == S_CHECK && act_q == lpht_pkg::ACT_INSERT) begin
			if (!used_rd_q) begin
				used_we = 1'b1;
				used_wd = 1'b1;
				kv_we = 1'b1;
			end else if (key_rd_q == key_q) begin
				kv_we = 1'b1;
			end
		end
	end

	// Slot memories with registered reads.
	always_ff @(posedge clk) begin
		if (used_we) used_mem[wr_addr] <= used_wd;
		if (kv_we) begin
			key_mem[wr_addr] <= key_q;
			val_mem[wr_addr] <= val_q;
		end
		used_rd_q <= used_mem[slot_q];
		key_rd_q <= key_mem[slot_q];
		val_rd_q <= val_mem[slot_q];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sweep_q <= '0;
			coll_q <= '0;
			occ_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT, S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == (SW+1)'(lpht_pkg::TableDepth - 1)) begin
						sweep_q <= '0;
						state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
					end
				end
				S_IDLE: if (start) begin
					act_q <= action;
					key_q <= lookup_key;
					val_q <= new_value;
					m_q <= m_eff;
					att_q <= '0;
					found_q <= '0;
					probes_q <= '0;
					if (action == lpht_pkg::ACT_CLEAR) begin
						coll_q <= '0;
						occ_q <= '0;
						status_q <= lpht_pkg::ST_CLEARED;
						state_q <= S_CLEAR;
					end else if ((action == lpht_pkg::ACT_INSERT ||
							action == lpht_pkg::ACT_SEARCH) && m_eff != '0) begin
						state_q <= S_HASH;
					end else begin
						status_q <= (action == lpht_pkg::ACT_INSERT) ?
							lpht_pkg::ST_FULL : lpht_pkg::ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				S_HASH: if (hrsp.done) begin
					slot_q <= hrsp.home;
					state_q <= S_READ;
				end
				S_READ: state_q <= S_WAIT;
				S_WAIT: state_q <= S_CHECK;
				S_CHECK: begin
					state_q <= S_DONE;
					if (act_q == lpht_pkg::ACT_INSERT) begin
						if (!used_rd_q) begin
							occ_q <= occ_q + 1'b1;
							status_q <= lpht_pkg::ST_INSERTED;
						end else if (key_rd_q == key_q) begin
							status_q <= lpht_pkg::ST_UPDATED;
						end else begin
							if (att_q == '0 && coll_q != 32'hffffffff)
								coll_q <= coll_q + 1'b1;
							if (att_q + 1'b1 >= m_q) begin
								status_q <= lpht_pkg::ST_FULL;
							end else begin
								att_q <= att_q + 1'b1;
								slot_q <= slot_next[SW-1:0];
								state_q <= S_READ;
							end
						end
					end else begin
						if (!used_rd_q) begin
							status_q <= lpht_pkg::ST_NOT_FOUND;
							probes_q <= att_q;
						end else if (key_rd_q == key_q) begin
							status_q <= lpht_pkg::ST_FOUND;
							found_q <= val_rd_q;
							probes_q <= att_q;
						end else if (att_q + 1'b1 >= m_q) begin
							status_q <= lpht_pkg::ST_NOT_FOUND;
							probes_q <= att_q + 1'b1;
						end else begin
							att_q <= att_q + 1'b1;
							slot_q <= slot_next[SW-1:0];
							state_q <= S_READ;
						end
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign found_value = found_q;
	assign probe_count = probes_q;
	assign collision_total = coll_q;
	assign occupied_total = occ_q;
endmodule

### design/lpht_hash.sv
// Home slot unit: reduces the key, multiplies over two slices of 16 and 15
// bits, folds by the Mersenne prime, then takes the remainder by the size bit-serially.
module lpht_hash (
	input  logic clk,
	input  logic arst_n,
	input  lpht_pkg::hash_req_t req,
	output lpht_pkg::hash_rsp_t rsp
);
	localparam logic [2:0] H_IDLE = 3'd0;
	localparam logic [2:0] H_MUL = 3'd1;
	localparam logic [2:0] H_FOLD = 3'd2;
	localparam logic [2:0] H_MOD = 3'd3;
	localparam logic [2:0] H_DONE = 3'd4;

	logic [2:0] state_q;
	logic [1:0] slice_q;
	logic [62:0] acc_q;
	logic [30:0] k_q;
	logic [30:0] mult_q;
	logic [30:0] offset_q;
	logic [lpht_pkg::SizeW-1:0] size_q;
	logic [lpht_pkg::SizeW-1:0] rem_q;
	logic [5:0] bit_q;
	logic [30:0] h_q;
	logic [63:0] kx;
	logic [32:0] kfold;
	logic [31:0] kred;
	logic [15:0] mslice;
	logic [46:0] partial;
	logic [32:0] hfold;
	logic [31:0] hred;
	logic [lpht_pkg::SizeW:0] rem_sh;

	// Key reduction: the sign-extended key folded by 2^31 = 1 (mod p).
	always_comb begin
		kx = {{32{req.key[31]}}, req.key};
		kfold = {2'b0, kx[30:0]} + {2'b0, kx[61:31]} + {31'b0, kx[63:62]};
		kred = {1'b0, kfold[30:0]} + {30'b0, kfold[32:31]};
		if (kred >= {1'b0, lpht_pkg::HashPrime})
			kred = kred - {1'b0, lpht_pkg::HashPrime};
	end

	// One 31 by 16 partial product a cycle; also the fold by the prime and the remainder shift.
	always_comb begin
		mslice = (slice_q == 2'd0) ? k_q[15:0] : {1'b0, k_q[30:16]};
		partial = {16'b0, mult_q} * {31'b0, mslice};
		hfold = {2'b0, acc_q[30:0]} + {2'b0, acc_q[61:31]} + {32'b0, acc_q[62]};
		hred = {1'b0, hfold[30:0]} + {30'b0, hfold[32:31]};
		if (hred >= {1'b0, lpht_pkg::HashPrime})
			hred = hred - {1'b0, lpht_pkg::HashPrime};
		rem_sh = {rem_q, h_q[bit_q[4:0]]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			unique case (state_q)
				H_IDLE: if (req.start) state_q <= H_MUL;
				H_MUL: if (slice_q == 2'd1) state_q <= H_FOLD;
				H_FOLD: state_q <= H_MOD;
				H_MOD: if (bit_q == 6'd0) state_q <= H_DONE;
				H_DONE: state_q <= H_IDLE;
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				k_q <= kred[30:0];
				mult_q <= req.mult;
				offset_q <= req.offset;
				size_q <= req.size;
				acc_q <= {32'b0, req.offset};
				slice_q <= 2'd0;
			end
			H_MUL: begin
				acc_q <= acc_q + ((slice_q == 2'd0) ? {16'b0, partial} :
					{partial[46:0], 16'b0});
				slice_q <= slice_q + 2'd1;
			end
			H_FOLD: begin
				h_q <= hred[30:0];
				rem_q <= '0;
				bit_q <= 6'd30;
			end
			H_MOD: begin
				// Restoring division step, remainder only.
				if (rem_sh >= {1'b0, size_q})
					rem_q <= rem_sh[lpht_pkg::SizeW-1:0] - size_q;
				else
					rem_q <= rem_sh[lpht_pkg::SizeW-1:0];
				bit_q <= bit_q - 6'd1;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = (state_q == H_DONE);
	assign rsp.home = rem_q[lpht_pkg::SlotW-1:0];
endmodule

### design/lpht_checker.sv
`include "linear_probe_hash_table_core_macros.svh"
// Port-level checks on the table core.
module lpht_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] status,
	input logic [31:0] found_value,
	input logic [10:0] occupied_total,
	input logic pready
);
	// A request is never answered in the cycle right after it is taken.
	`LPHT_ASSERT_NEXT(a_no_instant, clk, arst_n, start && !busy, !done)
	// The block is free while the result is shown.
	`LPHT_ASSERT_IMP(a_free_after, clk, arst_n, done, !busy)
	// Only a successful search returns a value.
	`LPHT_ASSERT_IMP(a_found_zero, clk, arst_n, done && status != lpht_pkg::ST_FOUND, found_value == 32'd0)
	// A clear leaves no slot occupied.
	`LPHT_ASSERT_IMP(a_clear_empty, clk, arst_n, done && status == lpht_pkg::ST_CLEARED, occupied_total == 11'd0)
	// The register port never waits.
	`LPHT_ASSERT_IMP(a_ready, clk, arst_n, 1'b1, pready)
endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.found_value(found_value),
	.occupied_total(occupied_total),
	.pready(pready)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Expected answer for one request.
typedef struct packed {
	logic [2:0] status;
	logic [31:0] found_value;
	logic [10:0] probe_count;
	logic [31:0] collision_total;
	logic [10:0] occupied_total;
} table_answer_t;

// Mirror of the hash table that works out and checks every answer.
class hash_table_scoreboard;
	bit [30:0] multiplier = 31'd1;
	bit [30:0] offset = 31'd0;
	bit [10:0] size_reg = 11'd1024;
	bit used [lpht_pkg::TableDepth];
	bit [31:0] keys [lpht_pkg::TableDepth];
	bit [31:0] values [lpht_pkg::TableDepth];
	bit [31:0] collisions = 0;
	bit [10:0] occupied = 0;
	table_answer_t pending_answers [$];
	int unsigned mismatches = 0;
	int unsigned answers_checked = 0;
	int unsigned requests_noted = 0;

	function void set_register(logic [1:0] idx, logic [31:0] data);
		case (idx)
			lpht_pkg::REG_MULT: multiplier = data[30:0];
			lpht_pkg::REG_OFFSET: offset = data[30:0];
			lpht_pkg::REG_SIZE: size_reg = data[10:0];
			default: ;
		endcase
	endfunction

	// Home slot: universal hash reduced by the Mersenne prime, then by the size.
	function int unsigned home_of(bit [31:0] key, int unsigned m);
		longint unsigned k;
		longint unsigned h;
		k = {{32{key[31]}}, key};
		k = k % 64'd2147483647;
		h = (longint'(multiplier) * k + longint'(offset)) % 64'd2147483647;
		return int'(h % m);
	endfunction

	function void note_request(logic [1:0] act, logic [31:0] key, logic [31:0] val);
		table_answer_t a;
		int unsigned m;
		int unsigned home;
		int unsigned s;
		int unsigned att;
		m = (size_reg > lpht_pkg::TableDepth) ? lpht_pkg::TableDepth : size_reg;
		a.status = lpht_pkg::ST_NOT_FOUND;
		a.found_value = 0;
		a.probe_count = 0;
		requests_noted++;
		if (act == lpht_pkg::ACT_INSERT) begin
			a.status = lpht_pkg::ST_FULL;
			if (m != 0) begin
				home = home_of(key, m);
				for (att = 0; att < m; att++) begin
					s = home + att;
					if (s >= m)
						s -= m;
					if (!used[s]) begin
						used[s] = 1'b1;
						keys[s] = key;
						values[s] = val;
						occupied++;
						a.status = lpht_pkg::ST_INSERTED;
						break;
					end
					if (keys[s] == key) begin
						values[s] = val;
						a.status = lpht_pkg::ST_UPDATED;
						break;
					end
					if (att == 0 && collisions != 32'hffffffff)
						collisions++;
				end
			end
		end else if (act == lpht_pkg::ACT_SEARCH) begin
			if (m != 0) begin
				home = home_of(key, m);
				for (att = 0; att < m; att++) begin
					s = home + att;
					if (s >= m)
						s -= m;
					if (!used[s])
						break;
					if (keys[s] == key) begin
						a.status = lpht_pkg::ST_FOUND;
						a.found_value = values[s];
						break;
					end
				end
				a.probe_count = att[10:0];
			end
		end else if (act == lpht_pkg::ACT_CLEAR) begin
			foreach (used[i])
				used[i] = 1'b0;
			occupied = 0;
			collisions = 0;
			a.status = lpht_pkg::ST_CLEARED;
		end
		a.collision_total = collisions;
		a.occupied_total = occupied;
		pending_answers.push_back(a);
	endfunction

	function void check_result(table_answer_t got);
		table_answer_t want;
		answers_checked++;
		if (pending_answers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result with no request outstanding: status %0d", got.status);
			return;
		end
		want = pending_answers.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"Mismatch: expected st %0d val %h probes %0d coll %0d occ %0d, ",
					"got st %0d val %h probes %0d coll %0d occ %0d"},
					want.status, want.found_value, want.probe_count,
					want.collision_total, want.occupied_total,
					got.status, got.found_value, got.probe_count,
					got.collision_total, got.occupied_total);
		end
	endfunction

	function int pending();
		return pending_answers.size();
	endfunction
endclass

module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic signed [31:0] lookup_key = '0;
	logic signed [31:0] new_value = '0;
	logic done;
	logic [2:0] status;
	logic signed [31:0] found_value;
	logic [10:0] probe_count;
	logic [31:0] collision_total;
	logic [10:0] occupied_total;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	localparam int unsigned CycleLimit = 10000000;

	hash_table_scoreboard sb = new();
	logic [31:0] key_pool [16];
	int unsigned cycles = 0;

	linear_probe_hash_table_core dut (.*);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Results are taken on the edge that ends their strobe cycle; the run is bounded here too.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("linear_probe_hash_table_core verification failed");
			$finish;
		end
		if (arst_n && done === 1'b1)
			sb.check_result('{status, found_value, probe_count, collision_total,
				occupied_total});
	end

	// Register write through the setup and access phases of the bus transfer, then an idle bus phase.
	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	// Present one request and hold it until the block takes it.
	task automatic send_request(logic [1:0] act, logic [31:0] key, logic [31:0] val);
		start <= 1'b1;
		action <= act;
		lookup_key <= key;
		new_value <= val;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(act, key, val);
	endtask

	// Wait until every answer is in and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic refill_keys(int unsigned spread);
		foreach (key_pool[i])
			key_pool[i] = (spread == 0) ? $urandom : i * spread - 32'd24;
	endtask

	// Random requests in bursts; most keys come from a small pool so that
	// updates, hits and collisions happen often.
	task automatic random_requests(int unsigned count);
		int unsigned left;
		int unsigned burst;
		int unsigned pick;
		logic [1:0] act;
		logic [31:0] key;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					act = lpht_pkg::ACT_INSERT;
				else if (pick < 94)
					act = lpht_pkg::ACT_SEARCH;
				else if (pick < 97)
					act = lpht_pkg::ACT_CLEAR;
				else
					act = 2'd3;
				key = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 15)];
				send_request(act, key, $urandom);
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// Directed: extreme keys and values, every action, the unused code.
		send_request(lpht_pkg::ACT_INSERT, 32'h0, 32'h7fffffff);
		send_request(lpht_pkg::ACT_INSERT, 32'hffffffff, 32'h80000000);
		send_request(lpht_pkg::ACT_INSERT, 32'h7fffffff, 32'hffffffff);
		send_request(lpht_pkg::ACT_INSERT, 32'h80000000, 32'h0);
		send_request(lpht_pkg::ACT_INSERT, 32'h0, 32'h12345678);
		send_request(lpht_pkg::ACT_SEARCH, 32'h0, 32'h0);
		send_request(lpht_pkg::ACT_SEARCH, 32'hffffffff, 32'hffffffff);
		send_request(lpht_pkg::ACT_SEARCH, 32'h55555555, 32'h0);
		send_request(2'd3, 32'haaaaaaaa, 32'hffffffff);
		send_request(lpht_pkg::ACT_CLEAR, 32'h0, 32'h0);
		send_request(lpht_pkg::ACT_SEARCH, 32'h0, 32'h0);
		drain();

		// Single slot with the largest multiplier and offset: full and collisions.
		write_register(lpht_pkg::REG_MULT, 32'hffffffff);
		write_register(lpht_pkg::REG_OFFSET, 32'h7ffffffe);
		write_register(lpht_pkg::REG_SIZE, 32'd1);
		send_request(lpht_pkg::ACT_INSERT, 32'h11, 32'h1);
		send_request(lpht_pkg::ACT_INSERT, 32'h22, 32'h2);
		send_request(lpht_pkg::ACT_SEARCH, 32'h22, 32'h0);
		send_request(lpht_pkg::ACT_INSERT, 32'h11, 32'h3);
		send_request(lpht_pkg::ACT_SEARCH, 32'h11, 32'h0);
		refill_keys(0);
		random_requests(60);
		drain();

		// Size zero: nothing can be stored or found.
		write_register(lpht_pkg::REG_SIZE, 32'd0);
		random_requests(30);
		drain();

		// A small table with random hash terms; older entries stay behind.
		write_register(lpht_pkg::REG_MULT, $urandom_range(1, 32'h7ffffffe));
		write_register(lpht_pkg::REG_OFFSET, $urandom_range(0, 32'h7ffffffe));
		write_register(lpht_pkg::REG_SIZE, 32'd13);
		refill_keys(7);
		random_requests(160);
		drain();

		// Size beyond the table depth is clipped; minimum hash terms.
		write_register(lpht_pkg::REG_MULT, 32'd0);
		write_register(lpht_pkg::REG_OFFSET, 32'd0);
		write_register(lpht_pkg::REG_SIZE, 32'h7ff);
		refill_keys(1024);
		random_requests(100);
		drain();

		// Mid-sized table with fresh random terms.
		write_register(lpht_pkg::REG_MULT, $urandom);
		write_register(lpht_pkg::REG_OFFSET, $urandom);
		write_register(lpht_pkg::REG_SIZE, 32'd64);
		refill_keys(0);
		random_requests(230);
		drain();
		repeat (50) @(posedge clk);

		$display("Covered %0d requests and %0d answers across six table settings.",
			sb.requests_noted, sb.answers_checked);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("linear_probe_hash_table_core verification clean");
		else
			$display("linear_probe_hash_table_core verification failed");
		$finish;
	end
endmodule
